/* hw/rtl/ctjd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctjd_pkg: shared types and constants of the crash, tilt and jerk detector
// Item layouts, accident and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ctjd_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_CRASH    = 3'd1,
    KIND_FALL     = 3'd2,
    KIND_STOP     = 3'd3,
    KIND_COMBINED = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    EV_SUSPICIOUS = 2'd0,
    EV_CONFIRMED  = 2'd1,
    EV_CLEARED    = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRASH_ACCEL = 3'd0,
    CFG_TILT        = 3'd1,
    CFG_JERK        = 3'd2,
    CFG_CONFIRM     = 3'd3,
    CFG_CLEAR       = 3'd4,
    CFG_HOLD        = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] RST_CRASH_ACCEL = 16'd400;
  localparam logic [14:0] RST_TILT        = 15'd6000;
  localparam logic [22:0] RST_JERK        = 23'd1000;
  localparam logic [7:0]  RST_CONFIRM     = 8'd3;
  localparam logic [7:0]  RST_CLEAR       = 8'd5;
  localparam logic [31:0] RST_HOLD        = 32'd30000;

  // Two or more hits on one frame give the combined kind.
  localparam logic [1:0] MULTI_HIT = 2'd2;

  typedef struct packed {
    logic [15:0] crash_accel_limit;
    logic [14:0] tilt_limit;
    logic [22:0] jerk_limit;
    logic [7:0]  confirm_frames;
    logic [7:0]  clear_frames;
    logic [31:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic               item_kind;
    logic               frame_valid;
    logic [15:0]        total_accel;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [23:0] jerk;
    logic [31:0]        sample_time;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [1:0]         reported_mode;
    logic [2:0]         accident_kind;
    logic [15:0]        accel_at_event;
    logic signed [15:0] angle_x_at_event;
    logic signed [15:0] angle_y_at_event;
    logic signed [23:0] jerk_at_event;
    logic [31:0]        time_at_event;
    logic [31:0]        accident_total;
  } out_item_t;

  // Classified item as it waits between front and back.
  typedef struct packed {
    kind_e    kind;
    in_item_t item;
  } cls_item_t;

endpackage

/* hw/rtl/ctjd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctjd_front: input stage and frame classifier
// Registers each accepted item together with its accident kind.
// ----------------------------------------------------------------------------
module ctjd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctjd_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ctjd_pkg::in_item_t  in_item_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output ctjd_pkg::cls_item_t push_data_o
);

  logic                fr_valid_q, fr_valid_d;
  ctjd_pkg::cls_item_t fr_data_q;
  ctjd_pkg::kind_e     kind;
  logic [16:0]         ax_ext, ay_ext, ax_mag, ay_mag;
  logic                crash, fall, stop;
  logic [1:0]          hits;
  logic                take;

  always_comb begin
    ax_ext = {in_item_i.angle_x[15], in_item_i.angle_x};
    ay_ext = {in_item_i.angle_y[15], in_item_i.angle_y};
    // Magnitude over the full 16-bit range, so the most negative value is kept.
    ax_mag = in_item_i.angle_x[15] ? (17'd0 - ax_ext) : ax_ext;
    ay_mag = in_item_i.angle_y[15] ? (17'd0 - ay_ext) : ay_ext;
    crash  = in_item_i.total_accel > cfg_i.crash_accel_limit;
    fall   = (ax_mag > {2'b00, cfg_i.tilt_limit}) || (ay_mag > {2'b00, cfg_i.tilt_limit});
    stop   = !in_item_i.jerk[23] && (in_item_i.jerk[22:0] > cfg_i.jerk_limit);
    hits   = {1'b0, crash} + {1'b0, fall} + {1'b0, stop};
    priority if (hits == 2'd0) begin
      kind = ctjd_pkg::KIND_NONE;
    end else if (hits >= ctjd_pkg::MULTI_HIT) begin
      kind = ctjd_pkg::KIND_COMBINED;
    end else if (crash) begin
      kind = ctjd_pkg::KIND_CRASH;
    end else if (fall) begin
      kind = ctjd_pkg::KIND_FALL;
    end else begin
      kind = ctjd_pkg::KIND_STOP;
    end
  end

  assign in_ready_o   = !fr_valid_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = fr_valid_q;
  assign push_data_o  = fr_data_q;

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (take) begin
      fr_valid_d = 1'b1;
    end else if (push_ready_i) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fr_data_q <= '{kind: kind, item: in_item_i};
    end
  end

endmodule

/* hw/rtl/ctjd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctjd_queue: short queue between classifier and mode machine
// Holds classified items so that either side can stall on its own.
// ----------------------------------------------------------------------------
module ctjd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  ctjd_pkg::cls_item_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output ctjd_pkg::cls_item_t pop_data_o
);

  ctjd_pkg::cls_item_t               mem_q [ctjd_pkg::QDEPTH];
  logic [ctjd_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ctjd_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              push, pop;

  localparam logic [ctjd_pkg::QPTR_W-1:0] LAST = ctjd_pkg::QPTR_W'(ctjd_pkg::QDEPTH - 1);
  localparam logic [ctjd_pkg::QCNT_W-1:0] FULL = ctjd_pkg::QCNT_W'(ctjd_pkg::QDEPTH);

  assign push_ready_o = cnt_q != FULL;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/ctjd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctjd_back: mode machine and event output register
// Debounces accident kinds, times the accident hold and emits events.
// ----------------------------------------------------------------------------
module ctjd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctjd_pkg::cfg_t      cfg_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  ctjd_pkg::cls_item_t pop_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctjd_pkg::out_item_t out_item_o
);

  typedef enum logic [1:0] {
    MODE_UNKNOWN    = 2'd0,
    MODE_NORMAL     = 2'd1,
    MODE_SUSPICIOUS = 2'd2,
    MODE_ACCIDENT   = 2'd3
  } mode_e;

  mode_e               mode_q, mode_d, mode_eff;
  ctjd_pkg::kind_e     last_kind_q, last_kind_d;
  logic [7:0]          abn_run_q, abn_run_d, nrm_run_q, nrm_run_d, abn_inc, nrm_inc;
  logic [31:0]         acc_start_q, acc_start_d, acc_cnt_q, acc_cnt_d, elapsed;
  logic                out_valid_q, out_valid_d;
  ctjd_pkg::out_item_t out_q, out_d;
  logic                step, emit, with_frame, expired;
  ctjd_pkg::event_e    ev;
  ctjd_pkg::in_item_t  it;
  ctjd_pkg::kind_e     kind;

  assign it          = pop_data_i.item;
  assign kind        = pop_data_i.kind;
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign step        = pop_valid_i && pop_ready_o;
  assign elapsed     = it.now_ms - acc_start_q;
  assign expired     = elapsed >= cfg_i.hold_ms;
  assign abn_inc     = (abn_run_q == 8'hFF) ? abn_run_q : abn_run_q + 8'd1;
  assign nrm_inc     = (nrm_run_q == 8'hFF) ? nrm_run_q : nrm_run_q + 8'd1;
  assign mode_eff    = (mode_q == MODE_UNKNOWN) ? MODE_NORMAL : mode_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    mode_d      = mode_q;
    last_kind_d = last_kind_q;
    abn_run_d   = abn_run_q;
    nrm_run_d   = nrm_run_q;
    acc_start_d = acc_start_q;
    acc_cnt_d   = acc_cnt_q;
    emit        = 1'b0;
    with_frame  = 1'b0;
    ev          = ctjd_pkg::EV_SUSPICIOUS;
    if (step) begin
      if (it.item_kind) begin
        if (mode_q == MODE_ACCIDENT && expired) begin
          mode_d      = MODE_NORMAL;
          last_kind_d = ctjd_pkg::KIND_NONE;
          abn_run_d   = '0;
          nrm_run_d   = '0;
          emit        = 1'b1;
          ev          = ctjd_pkg::EV_CLEARED;
        end
      end else if (it.frame_valid) begin
        // The first valid frame lifts an unknown mode to normal before judging.
        mode_d = mode_eff;
        unique case (mode_eff)
          MODE_NORMAL: begin
            if (kind != ctjd_pkg::KIND_NONE) begin
              mode_d      = MODE_SUSPICIOUS;
              abn_run_d   = 8'd1;
              nrm_run_d   = '0;
              last_kind_d = kind;
              emit        = 1'b1;
              with_frame  = 1'b1;
              ev          = ctjd_pkg::EV_SUSPICIOUS;
            end
          end
          MODE_SUSPICIOUS: begin
            if (kind != ctjd_pkg::KIND_NONE) begin
              abn_run_d = abn_inc;
              nrm_run_d = '0;
              if (kind == ctjd_pkg::KIND_COMBINED || last_kind_q == ctjd_pkg::KIND_NONE) begin
                last_kind_d = kind;
              end
              if (abn_inc >= cfg_i.confirm_frames) begin
                mode_d      = MODE_ACCIDENT;
                acc_start_d = it.now_ms;
                acc_cnt_d   = acc_cnt_q + 32'd1;
                emit        = 1'b1;
                with_frame  = 1'b1;
                ev          = ctjd_pkg::EV_CONFIRMED;
              end
            end else begin
              nrm_run_d = nrm_inc;
              abn_run_d = '0;
              if (nrm_inc >= cfg_i.clear_frames) begin
                mode_d      = MODE_NORMAL;
                last_kind_d = ctjd_pkg::KIND_NONE;
                nrm_run_d   = '0;
              end
            end
          end
          MODE_ACCIDENT: begin
            if (expired) begin
              mode_d      = MODE_NORMAL;
              last_kind_d = ctjd_pkg::KIND_NONE;
              abn_run_d   = '0;
              nrm_run_d   = '0;
              emit        = 1'b1;
              ev          = ctjd_pkg::EV_CLEARED;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    out_d.event_kind       = ev;
    out_d.reported_mode    = mode_d;
    out_d.accident_kind    = last_kind_d;
    out_d.accel_at_event   = with_frame ? it.total_accel : '0;
    out_d.angle_x_at_event = with_frame ? it.angle_x : '0;
    out_d.angle_y_at_event = with_frame ? it.angle_y : '0;
    out_d.jerk_at_event    = with_frame ? it.jerk : '0;
    out_d.time_at_event    = with_frame ? it.sample_time : '0;
    out_d.accident_total   = acc_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_UNKNOWN;
      last_kind_q <= ctjd_pkg::KIND_NONE;
      abn_run_q   <= '0;
      nrm_run_q   <= '0;
      acc_start_q <= '0;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      last_kind_q <= last_kind_d;
      abn_run_q   <= abn_run_d;
      nrm_run_q   <= nrm_run_d;
      acc_start_q <= acc_start_d;
      acc_cnt_q   <= acc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= out_d;
    end
  end

  // Normal mode is always entered with both run counters and the kind cleared.
  a_normal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_NORMAL |-> abn_run_q == '0 && nrm_run_q == '0 &&
                              last_kind_q == ctjd_pkg::KIND_NONE)
    else $error("normal mode with stale debounce state");

  a_unknown_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_UNKNOWN |-> acc_cnt_q == '0 && last_kind_q == ctjd_pkg::KIND_NONE)
    else $error("unknown mode after activity");

  a_confirm_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit && ev == ctjd_pkg::EV_CONFIRMED |=>
      acc_cnt_q == $past(acc_cnt_q) + 32'd1 && mode_q == MODE_ACCIDENT)
    else $error("confirmed event without counting the accident");

  a_cleared_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.event_kind == ctjd_pkg::EV_CLEARED |->
      out_q.time_at_event == '0 && out_q.accident_kind == ctjd_pkg::KIND_NONE &&
      out_q.reported_mode == MODE_NORMAL)
    else $error("cleared event carries frame data");

endmodule

/* hw/rtl/crash_tilt_jerk_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crash_tilt_jerk_detector: accident detector on motion frames and timeouts
//
// Input channel (in_valid_i / in_ready_o / in_item_i) takes motion frames and
// receive timeouts. Output channel (out_valid_o / out_ready_i / out_item_o)
// gives suspicious, confirmed and cleared events; most items give no event.
// Configuration is written via cfg_we_i / cfg_idx_i / cfg_data_i, one register
// per cycle; the user must write only while no item is in flight (unchecked).
//
// An item is classified in the input stage, waits in a two-entry queue and is
// then run through the mode machine, which loads the output register. The
// block takes one item per cycle while in_ready_o is high; the mode machine
// handles one item per cycle and steps only while the output register is
// empty or being taken.
//
// Reset clears the mode to unknown, the counters to zero and the registers to
// their defaults; items are taken from the first cycle after reset. When the
// receiver stalls, the held event stays put, the queue fills and then
// in_ready_o drops until the event is taken.
// ----------------------------------------------------------------------------
module crash_tilt_jerk_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ctjd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ctjd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ctjd_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ctjd_pkg::out_item_t                 out_item_o
);

  ctjd_pkg::cfg_t      cfg_q, cfg_d;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  ctjd_pkg::cls_item_t push_data, pop_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ctjd_pkg::CFG_CRASH_ACCEL: cfg_d.crash_accel_limit = cfg_data_i[15:0];
        ctjd_pkg::CFG_TILT:        cfg_d.tilt_limit        = cfg_data_i[14:0];
        ctjd_pkg::CFG_JERK:        cfg_d.jerk_limit        = cfg_data_i[22:0];
        ctjd_pkg::CFG_CONFIRM:     cfg_d.confirm_frames    = cfg_data_i[7:0];
        ctjd_pkg::CFG_CLEAR:       cfg_d.clear_frames      = cfg_data_i[7:0];
        ctjd_pkg::CFG_HOLD:        cfg_d.hold_ms           = cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crash_accel_limit <= ctjd_pkg::RST_CRASH_ACCEL;
      cfg_q.tilt_limit        <= ctjd_pkg::RST_TILT;
      cfg_q.jerk_limit        <= ctjd_pkg::RST_JERK;
      cfg_q.confirm_frames    <= ctjd_pkg::RST_CONFIRM;
      cfg_q.clear_frames      <= ctjd_pkg::RST_CLEAR;
      cfg_q.hold_ms           <= ctjd_pkg::RST_HOLD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ctjd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ctjd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ctjd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
